FILE: sv/srks_pkg.sv
// shared types and constants for the stable record key sorter
`timescale 1ns / 1ps

package srks_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int PHASE_W     = $clog2(MAX_RECORDS);
  localparam int KEY_W       = 64;
  localparam int TAG_W       = 16;

  typedef struct packed {
    logic [KEY_W-1:0] sort_key;
    logic [TAG_W-1:0] record_tag;
    logic             is_last;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] out_key;
    logic [TAG_W-1:0] out_tag;
    logic             out_last;
    logic             overflow;
  } out_item_t;

  // contents of one cell of the chain
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } cell_data_t;

  // control broadcast to every cell
  typedef struct packed {
    logic shift;
    logic sort;
    logic desc;
  } cell_ctl_t;

endpackage

FILE: sv/srks_cell.sv
// one cell of the sorting chain: holds a record, shifts or swaps with a neighbor
`timescale 1ns / 1ps

module srks_cell
  import srks_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctl_t  ctl,
  input  logic       act_hi,
  input  cell_data_t lo,
  input  cell_data_t hi,
  input  logic       swap_lo,
  output cell_data_t data,
  output logic       swap_hi
);

  cell_data_t data_next;
  logic       hi_first;

  // upper neighbor must move ahead: strictly before, or this cell is empty
  always_comb begin
    hi_first = ctl.desc ? (hi.key > data.key) : (hi.key < data.key);
    swap_hi  = act_hi && hi.valid && (!data.valid || hi_first);
  end

  always_comb begin
    data_next = data;
    if (ctl.shift) begin
      data_next = hi;
    end else if (ctl.sort) begin
      if (swap_hi) begin
        data_next = hi;
      end else if (swap_lo) begin
        data_next = lo;
      end
    end
  end

  // only the valid bit is reset, key and tag just follow
  always_ff @(posedge clk) begin
    data.key <= data_next.key;
    data.tag <= data_next.tag;
    if (rst) begin
      data.valid <= 1'b0;
    end else begin
      data.valid <= data_next.valid;
    end
  end

endmodule

FILE: sv/stable_record_key_sorter.sv
// top level: stable record sorter built as a chain of compare-and-swap cells
// operation: records load one per cycle while in the load state; after the item marked last
//   the chain runs its odd-even transposition sort, then results leave from the head cell,
//   one result per cycle while out_stall is low
// input is held off from the last item until the final result of the run is taken, so a
//   new run cannot load while the previous run is still sorting or draining
// reset: rst (synchronous) empties every cell, clears counts, flags and sort_order
`timescale 1ns / 1ps

module stable_record_key_sorter
  import srks_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]         state;
  logic [CNT_W-1:0]   held_count;
  logic [PHASE_W-1:0] phase;
  logic               dropped_flag;
  logic               sort_order;
  logic               order_run;

  logic       in_acc;
  logic       out_acc;
  logic       full;
  cell_ctl_t  ctl;
  cell_data_t top_in;

  cell_data_t             cells [MAX_RECORDS];
  logic [MAX_RECORDS-1:0] swaps;

  // handshake: items only while loading, results only while draining
  assign in_stall  = (state != ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state == ST_OUT);
  assign out_acc   = out_valid && !out_stall;
  assign full      = (held_count == CNT_W'(MAX_RECORDS));

  // new records enter at the top cell; the top cell refills with empties on drain
  always_comb begin
    top_in.valid = (state == ST_LOAD);
    top_in.key   = in_data.sort_key;
    top_in.tag   = in_data.record_tag;
  end

  // one shift moves every cell down by one: loading and draining share it
  always_comb begin
    ctl.shift = (in_acc && !full) || out_acc;
    ctl.sort  = (state == ST_SORT);
    ctl.desc  = order_run;
  end

  // the chain: cell 0 is the head and feeds the result port
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    cell_data_t lo_d;
    cell_data_t hi_d;
    logic       swap_lo_d;
    logic       act_hi_d;

    if (i == 0) begin : g_head
      assign lo_d      = '0;
      assign swap_lo_d = 1'b0;
    end else begin : g_mid_lo
      assign lo_d      = cells[i-1];
      assign swap_lo_d = swaps[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign hi_d     = top_in;
      assign act_hi_d = 1'b0;
    end else begin : g_mid_hi
      assign hi_d     = cells[i+1];
      // even phases pair (0,1),(2,3)..; odd phases pair (1,2),(3,4)..
      assign act_hi_d = (phase[0] == 1'(i % 2));
    end

    srks_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .act_hi  (act_hi_d),
      .lo      (lo_d),
      .hi      (hi_d),
      .swap_lo (swap_lo_d),
      .data    (cells[i]),
      .swap_hi (swaps[i])
    );
  end

  always_comb begin
    out_data.out_key  = cells[0].key;
    out_data.out_tag  = cells[0].tag;
    out_data.out_last = (held_count == CNT_W'(1));
    out_data.overflow = dropped_flag;
  end

  // config register, to be written by the user only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      sort_order <= 1'b0;
    end else if (cfg_wr_en) begin
      sort_order <= cfg_wr_data;
    end
  end

  // run control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      held_count   <= '0;
      phase        <= '0;
      dropped_flag <= 1'b0;
      order_run    <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (full) begin
              dropped_flag <= 1'b1;
            end else begin
              held_count <= held_count + CNT_W'(1);
            end
            if (in_data.is_last) begin
              // order is sampled with the last item
              order_run <= sort_order;
              phase     <= '0;
              state     <= ST_SORT;
            end
          end
        end
        ST_SORT: begin
          phase <= phase + PHASE_W'(1);
          if (phase == PHASE_W'(MAX_RECORDS - 1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            held_count <= held_count - CNT_W'(1);
            if (held_count == CNT_W'(1)) begin
              dropped_flag <= 1'b0;
              state        <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // a result is offered only from an occupied head cell
  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cells[0].valid)
    else $error("result offered from empty head cell");

  // sorting and draining always have at least one record
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SORT || state == ST_OUT) |-> (held_count != '0))
    else $error("sort or drain with no records held");

  // the item marked last always starts the sort
  a_last_starts_sort: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_data.is_last) |=> (state == ST_SORT))
    else $error("last item did not start sorting");

  // count never exceeds the chain length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(MAX_RECORDS))
    else $error("held count beyond capacity");
`endif

endmodule

FILE: tb/testbench.sv
// testbench for the stable record key sorter: directed and random runs checked against a stable sort
`timescale 1ns / 1ps

module testbench
  import srks_pkg::*;
;

  localparam int SETTLE_CYCLES = 80;   // idle wait that covers the chain's sort phases with margin
  localparam int PHASE_ITEMS   = 100;  // least number of random items per idling mix

  // tracks the records of the run being loaded and the sorted results still due
  class sorted_run_model;
    logic [KEY_W-1:0] held_keys[$];
    logic [TAG_W-1:0] held_tags[$];
    bit               dropped;
    bit               descending;
    out_item_t        due_results[$];
    int               mismatches;
    int               records_seen;
    int               results_seen;
    int               runs_done;
    int               overflow_runs;

    function int pending();
      return due_results.size();
    endfunction

    function bit goes_ahead(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
      return descending ? (a > b) : (a < b);
    endfunction

    // stable insertion sort of the held run, queued as expected results
    function void emit_sorted_run();
      logic [KEY_W-1:0] keys[];
      logic [TAG_W-1:0] tags[];
      logic [KEY_W-1:0] k;
      logic [TAG_W-1:0] t;
      out_item_t        res;
      int               n;
      int               j;
      n = held_keys.size();
      keys = new[n];
      tags = new[n];
      for (int i = 0; i < n; i++) begin
        keys[i] = held_keys[i];
        tags[i] = held_tags[i];
      end
      for (int i = 1; i < n; i++) begin
        k = keys[i];
        t = tags[i];
        j = i;
        while (j > 0 && goes_ahead(k, keys[j-1])) begin
          keys[j] = keys[j-1];
          tags[j] = tags[j-1];
          j--;
        end
        keys[j] = k;
        tags[j] = t;
      end
      for (int i = 0; i < n; i++) begin
        res.out_key  = keys[i];
        res.out_tag  = tags[i];
        res.out_last = (i == n - 1);
        res.overflow = dropped;
        due_results.push_back(res);
      end
      runs_done++;
      if (dropped) overflow_runs++;
      held_keys.delete();
      held_tags.delete();
      dropped = 1'b0;
    endfunction

    function void note_record(in_item_t it);
      records_seen++;
      if (held_keys.size() < MAX_RECORDS) begin
        held_keys.push_back(it.sort_key);
        held_tags.push_back(it.record_tag);
      end else begin
        dropped = 1'b1;
      end
      if (it.is_last) emit_sorted_run();
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual key=%h tag=%h last=%b ovf=%b",
                 $time, got.out_key, got.out_tag, got.out_last, got.overflow);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (got.out_key !== want.out_key) begin
        $display("%0t: out_key expected %h actual %h", $time, want.out_key, got.out_key);
        mismatches++;
      end
      if (got.out_tag !== want.out_tag) begin
        $display("%0t: out_tag expected %h actual %h", $time, want.out_tag, got.out_tag);
        mismatches++;
      end
      if (got.out_last !== want.out_last) begin
        $display("%0t: out_last expected %b actual %b", $time, want.out_last, got.out_last);
        mismatches++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow expected %b actual %b", $time, want.overflow, got.overflow);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_wr_en = 1'b0;
  logic      cfg_wr_data = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  sorted_run_model run_model = new();

  stable_record_key_sorter u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls at random at the current rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // every item taken from the output is checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) run_model.check_result(out_data);
  end

  // name bytes big-endian, padded with nul
  function automatic logic [KEY_W-1:0] pack_name(string s);
    logic [KEY_W-1:0] k;
    k = '0;
    for (int b = 0; b < s.len() && b < 8; b++) k[KEY_W-1-8*b -: 8] = s[b];
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] make_key();
    logic [KEY_W-1:0] k;
    string            s;
    int               len;
    s = "";
    case ($urandom_range(7))
      0, 1, 2, 3: k = {$urandom, $urandom};
      4, 5: begin
        // short names from few letters give shared prefixes and repeats
        len = $urandom_range(8);
        for (int b = 0; b < len; b++) s = {s, string'(8'($urandom_range(97, 100)))};
        k = pack_name(s);
      end
      6: k = {4'($urandom_range(1)), 56'h0, 4'($urandom_range(2))};
      default: k = $urandom_range(1) ? '1 : '0;
    endcase
    return k;
  endfunction

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    run_model.note_record(it);
  endtask

  task automatic send_directed(logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag, logic last);
    in_item_t it;
    it.sort_key   = key;
    it.record_tag = tag;
    it.is_last    = last;
    send_item(it);
  endtask

  task automatic send_run(int len);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      it.sort_key   = make_key();
      it.record_tag = 16'($urandom);
      it.is_last    = (i == len - 1);
      send_item(it);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (run_model.pending() != 0) @(posedge clk);
  endtask

  // register write only once the chain is empty and settled
  task automatic set_sort_order(bit desc);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= desc;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    run_model.descending = desc;
  endtask

  initial begin
    int phase_items;
    int len;
    int run_idx;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single record run, extremes of key and tag
    set_sort_order(1'b0);
    send_directed('1, 16'h0000, 1'b1);
    // ascending names with a prefix pair and a repeated name (stability)
    send_directed(pack_name("bob"),   16'h0001, 1'b0);
    send_directed(pack_name("al"),    16'h0002, 1'b0);
    send_directed(pack_name("alice"), 16'h0003, 1'b0);
    send_directed(pack_name("al"),    16'hffff, 1'b0);
    send_directed('0,                 16'h0005, 1'b0);
    send_directed('1,                 16'h0006, 1'b1);
    // descending marks with repeats and the top bit alone
    set_sort_order(1'b1);
    send_directed(64'd5,                  16'h0010, 1'b0);
    send_directed('1,                     16'h0011, 1'b0);
    send_directed(64'd5,                  16'h0012, 1'b0);
    send_directed('0,                     16'h0013, 1'b0);
    send_directed(64'h8000_0000_0000_0000, 16'h0014, 1'b0);
    send_directed(64'd5,                  16'h0015, 1'b1);
    // all keys equal: arrival order must hold
    send_directed(64'h1234, 16'haaaa, 1'b0);
    send_directed(64'h1234, 16'h5555, 1'b0);
    send_directed(64'h1234, 16'h0f0f, 1'b1);

    // random runs under three idling mixes
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 8;  recv_idle_pct = 62; end
        1: begin send_idle_pct = 62; recv_idle_pct = 8;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      set_sort_order(phase[0]);
      phase_items = 0;
      run_idx = 0;
      while (phase_items < PHASE_ITEMS) begin
        // first run of each mix hits the store limit: one over, exactly full, three over
        if (run_idx == 0) len = (phase == 0) ? MAX_RECORDS + 1 :
                                (phase == 1) ? MAX_RECORDS : MAX_RECORDS + 3;
        else if ($urandom_range(15) == 0) len = $urandom_range(60, 68);
        else len = $urandom_range(1, 12);
        send_run(len);
        phase_items += len;
        run_idx++;
        // now and then drain everything and pick a random order
        if ($urandom_range(2) == 0) set_sort_order(1'($urandom_range(1)));
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES + 20) @(posedge clk);
    $display("covered %0d records in %0d sorted runs, %0d of them with dropped records",
             run_model.records_seen, run_model.runs_done, run_model.overflow_runs);
    $display("checked %0d results in both orders under three stall mixes, %0d mismatches",
             run_model.results_seen, run_model.mismatches);
    if (run_model.mismatches == 0 && run_model.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", run_model.pending());
    $display("status: fail");
    $finish;
  end

endmodule
